FILE: src/alt_pkg.sv
// shared types, constants and the cosine table for the altitude controller
// no dependencies
package alt_pkg;

	localparam int COS_TABLE_DEPTH = 256;
	localparam int COS_IDX_W = $clog2(COS_TABLE_DEPTH + 1);

	localparam int DIV_DVD_W = 45;
	localparam int DIV_DSR_W = 31;
	localparam int DIV_QUO_W = 16;

	localparam logic [16:0] ANGLE_MAX = 17'd23040;
	localparam logic [DIV_DVD_W-1:0] ANGLE_HALF = DIV_DVD_W'(11520);

	localparam longint Q30_HALF_PI = 64'sd1686629713;
	localparam longint Q30_ONE = 64'sd1073741824;

	localparam logic [15:0] RST_HOVER = 16'd18022;
	localparam logic [15:0] RST_ALT_LIMIT = 16'hFC00;
	localparam logic [15:0] RST_STAGE_TICKS = 16'd100;

	localparam logic [15:0] LAND_STEP_1 = 16'd1966;
	localparam logic [15:0] LAND_STEP_2 = 16'd3932;
	localparam logic [15:0] LAND_STEP_3 = 16'd6554;
	localparam logic [17:0] LAND_TICKS_MAX = 18'h3FFFF;

	typedef logic [15:0] cos_tab_t [0:COS_TABLE_DEPTH];

	typedef enum logic [2:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_HOVER,
		REG_ALT_LIMIT,
		REG_USE_RANGE,
		REG_STAGE_TICKS
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LAND,
		ST_DIV_P,
		ST_WAIT_P,
		ST_DIV_R,
		ST_WAIT_R,
		ST_CPROD,
		ST_DIV_O,
		ST_WAIT_O,
		ST_MUL_P,
		ST_MUL_D,
		ST_MUL_I,
		ST_MUL_T,
		ST_SUM,
		ST_UPDATE,
		ST_DONE
	} ctl_state_t;

	// shift-subtract long division, truncating toward zero, used only for the table
	function automatic longint div_trunc(input longint num, input longint den);
		logic [63:0] n_mag;
		logic [63:0] d_mag;
		logic [63:0] quo;
		logic [63:0] rem;
		bit neg;
		neg = (num < 0) != (den < 0);
		n_mag = (num < 0) ? 64'(-num) : 64'(num);
		d_mag = (den < 0) ? 64'(-den) : 64'(den);
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], n_mag[b]};
			if (rem >= d_mag) begin
				rem = rem - d_mag;
				quo[b] = 1'b1;
			end
		end
		return neg ? -longint'(quo) : longint'(quo);
	endfunction

	// taylor series at q.30, rounded to q1.15
	function automatic logic [15:0] cos_entry(input int k);
		longint th;
		longint t2;
		longint term;
		longint acc;
		th = div_trunc(longint'(k) * Q30_HALF_PI, longint'(COS_TABLE_DEPTH));
		t2 = (th * th) >>> 30;
		term = Q30_ONE;
		acc = Q30_ONE;
		for (int n = 1; n <= 10; n++) begin
			term = -div_trunc(div_trunc(term * t2, Q30_ONE),
				longint'((2 * n - 1) * (2 * n)));
			acc = acc + term;
		end
		if (acc < 0) acc = 0;
		acc = (acc + 16384) >>> 15;
		if (acc > 32768) acc = 32768;
		return acc[15:0];
	endfunction

	function automatic cos_tab_t build_cos_tab();
		cos_tab_t t;
		for (int k = 0; k <= COS_TABLE_DEPTH; k++) t[k] = cos_entry(k);
		return t;
	endfunction

	localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

FILE: src/alt_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on alt_pkg
module alt_div import alt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_DVD_W-1:0] dividend,
	input  logic [DIV_DSR_W-1:0] divisor,
	output logic                 done,
	output logic                 ovf,
	output logic [DIV_QUO_W-1:0] quotient
);

	localparam int HI_W = DIV_DVD_W - DIV_QUO_W;
	localparam int CNT_W = $clog2(DIV_QUO_W);

	logic [DIV_DSR_W-1:0] rem_q;
	logic [DIV_DSR_W-1:0] dsr_q;
	logic [DIV_QUO_W-1:0] shf_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic                 ovf_q;
	logic [HI_W-1:0]      hi;
	logic [DIV_DSR_W:0]   cand;
	logic [DIV_DSR_W+1:0] diff;
	logic                 ge;

	assign hi = dividend[DIV_DVD_W-1:DIV_QUO_W];
	assign cand = {rem_q, shf_q[DIV_QUO_W-1]};
	assign diff = {1'b0, cand} - {2'b00, dsr_q};
	assign ge = !diff[DIV_DSR_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_QUO_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// quotient of 2^16 or more cannot be represented
			ovf_q <= DIV_DSR_W'(hi) >= divisor;
			rem_q <= DIV_DSR_W'(hi);
			shf_q <= dividend[DIV_QUO_W-1:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_DSR_W-1:0] : cand[DIV_DSR_W-1:0];
			shf_q <= {shf_q[DIV_QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign ovf = ovf_q;
	assign quotient = shf_q;

endmodule

FILE: src/altitude_pid_with_landing.sv
// altitude pid thrust controller with latched three-stage landing
// landing passes idle, land and done; pid passes the divider, multiply, sum and update states
// pid time is set by the bit-serial divider run three times (pitch index, roll index,
// hover offset); one transaction in flight, the next accepted only back in idle, which
// an output stall can delay
// async reset clears config to defaults, integrator, landing latch and counter
module altitude_pid_with_landing import alt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [15:0] setpoint_down,
	input  logic signed [15:0] position_down,
	input  logic signed [15:0] velocity_down,
	input  logic signed [15:0] pitch_angle,
	input  logic signed [15:0] roll_angle,
	input  logic [9:0]  tick_length,
	input  logic        land_request,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [14:0] thrust,
	output logic        landing_active,
	output logic        integrator_frozen
);

	ctl_state_t state_q, state_nx;

	logic [15:0] gain_p_q, gain_i_q, gain_d_q, stage_ticks_q;
	logic [14:0] hover_q;
	logic signed [15:0] alt_limit_q;
	logic use_range_q;

	logic signed [16:0] integ_q;
	logic landing_latched_q;
	logic [17:0] land_ticks_q;

	logic signed [16:0] err_q;
	logic signed [15:0] vel_q, pitch_q, roll_q;
	logic [9:0] dt_q;
	logic land_q;

	logic [15:0] cp_q, cr_q;
	logic [31:0] cprod_q;
	logic [16:0] offs_q;
	logic signed [33:0] pterm_q, dterm_q, iprod_q;
	logic signed [43:0] itot_q;
	logic signed [35:0] dsum_q;

	logic [14:0] res_thrust_q;
	logic res_land_q, res_frozen_q;
	logic out_valid_q;
	logic [14:0] thrust_q;
	logic landing_active_q, integrator_frozen_q;

	logic accept, out_load, div_start, div_done, div_ovf;
	logic [DIV_DVD_W-1:0] div_dividend;
	logic [DIV_DSR_W-1:0] div_divisor;
	logic [DIV_QUO_W-1:0] div_quo;
	logic [COS_IDX_W-1:0] cos_idx;

	logic signed [17:0] umax, umin, tclamp;
	logic signed [44:0] tsum;
	logic signed [18:0] thr_neg;
	logic signed [35:0] thr_c;
	logic frozen;
	logic signed [16:0] integ_nx;
	logic [15:0] land_sub;
	logic signed [16:0] land_thr;

	function automatic logic [DIV_DVD_W-1:0] angle_num(input logic signed [15:0] ang);
		logic [16:0] mag;
		mag = ang[15] ? (17'd0 - {1'b1, ang}) : {1'b0, ang};
		if (mag > ANGLE_MAX) mag = ANGLE_MAX;
		return DIV_DVD_W'(mag) * DIV_DVD_W'(COS_TABLE_DEPTH) + ANGLE_HALF;
	endfunction

	alt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.ovf      (div_ovf),
		.quotient (div_quo)
	);

	assign accept = in_valid && !in_stall;
	assign cos_idx = (div_quo > DIV_QUO_W'(COS_TABLE_DEPTH)) ?
		COS_IDX_W'(COS_TABLE_DEPTH) : div_quo[COS_IDX_W-1:0];

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if ($signed(position_down) < alt_limit_q || land_request ||
						landing_latched_q) state_nx = ST_LAND;
					else state_nx = ST_DIV_P;
				end
			end
			ST_LAND: state_nx = ST_DONE;
			ST_DIV_P: state_nx = ST_WAIT_P;
			ST_WAIT_P: if (div_done) state_nx = ST_DIV_R;
			ST_DIV_R: state_nx = ST_WAIT_R;
			ST_WAIT_R: if (div_done) state_nx = ST_CPROD;
			ST_CPROD: state_nx = ST_DIV_O;
			ST_DIV_O: state_nx = ST_WAIT_O;
			ST_WAIT_O: if (div_done) state_nx = ST_MUL_P;
			ST_MUL_P: state_nx = ST_MUL_D;
			ST_MUL_D: state_nx = ST_MUL_I;
			ST_MUL_I: state_nx = ST_MUL_T;
			ST_MUL_T: state_nx = ST_SUM;
			ST_SUM: state_nx = ST_UPDATE;
			ST_UPDATE: state_nx = ST_DONE;
			ST_DONE: if (out_load) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		div_start = 1'b0;
		div_dividend = angle_num(pitch_q);
		div_divisor = DIV_DSR_W'(ANGLE_MAX);
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_DIV_P: div_start = 1'b1;
			ST_DIV_R: begin
				div_start = 1'b1;
				div_dividend = angle_num(roll_q);
			end
			ST_DIV_O: begin
				div_start = 1'b1;
				div_dividend = {hover_q, 30'd0};
				div_divisor = cprod_q[DIV_DSR_W-1:0];
			end
			ST_DONE: out_load = !out_valid_q || !out_stall;
			default: in_stall = 1'b1;
		endcase
	end

	// pid arithmetic for the update step
	assign umax = (18'sd8192 - 18'(signed'({1'b0, hover_q}))) <<< 1;
	assign umin = (-18'sd8192 - 18'(signed'({1'b0, hover_q}))) <<< 1;
	assign frozen = (dsum_q >= 36'(umax) && !err_q[16]) ||
		(dsum_q <= 36'(umin) && (err_q[16] || err_q == '0));
	assign tsum = (45'(integ_q) <<< 1) + 45'(itot_q);
	assign tclamp = (tsum > 45'sd65536) ? 18'sd65536 :
		(tsum < -45'sd65536) ? -18'sd65536 : tsum[17:0];
	// halve with truncation toward zero
	assign integ_nx = 17'((tclamp + 18'(tclamp[17])) >>> 1);
	assign thr_c = (dsum_q > 36'(umin)) ? ((dsum_q < 36'(umax)) ? dsum_q : 36'(umax)) :
		36'(umin);
	assign thr_neg = 19'sd0 - thr_c[18:0];

	assign land_sub = (land_ticks_q < {2'b00, stage_ticks_q}) ? LAND_STEP_1 :
		(land_ticks_q < {1'b0, stage_ticks_q, 1'b0}) ? LAND_STEP_2 : LAND_STEP_3;
	assign land_thr = 17'(signed'({1'b0, hover_q})) - 17'(signed'({1'b0, land_sub}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			hover_q <= RST_HOVER[14:0];
			alt_limit_q <= RST_ALT_LIMIT;
			use_range_q <= 1'b1;
			stage_ticks_q <= RST_STAGE_TICKS;
			integ_q <= '0;
			landing_latched_q <= 1'b0;
			land_ticks_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_GAIN_P: gain_p_q <= cfg_data;
					REG_GAIN_I: gain_i_q <= cfg_data;
					REG_GAIN_D: gain_d_q <= cfg_data;
					REG_HOVER: hover_q <= cfg_data[14:0];
					REG_ALT_LIMIT: alt_limit_q <= cfg_data;
					REG_USE_RANGE: use_range_q <= cfg_data[0];
					REG_STAGE_TICKS: stage_ticks_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_LAND) begin
				landing_latched_q <= 1'b1;
				if (land_ticks_q != LAND_TICKS_MAX) land_ticks_q <= land_ticks_q + 1'b1;
			end
			if (state_q == ST_UPDATE && !frozen) integ_q <= integ_nx;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_q <= use_range_q ? (17'(setpoint_down) - 17'(position_down)) :
				17'(setpoint_down);
			vel_q <= velocity_down;
			pitch_q <= pitch_angle;
			roll_q <= roll_angle;
			dt_q <= tick_length;
			land_q <= $signed(position_down) < alt_limit_q || land_request ||
				landing_latched_q;
		end
		case (state_q)
			ST_LAND: begin
				res_thrust_q <= land_thr[16] ? 15'd0 : land_thr[14:0];
				res_land_q <= 1'b1;
				res_frozen_q <= 1'b0;
			end
			ST_WAIT_P: if (div_done) cp_q <= COS_TAB[cos_idx];
			ST_WAIT_R: if (div_done) cr_q <= COS_TAB[cos_idx];
			ST_CPROD: cprod_q <= cp_q * cr_q;
			ST_WAIT_O: if (div_done) offs_q <= div_ovf ? 17'd65536 : {1'b0, div_quo};
			ST_MUL_P: pterm_q <= 34'(err_q) * 34'(signed'({1'b0, gain_p_q}));
			ST_MUL_D: dterm_q <= 34'(vel_q) * 34'(signed'({1'b0, gain_d_q}));
			ST_MUL_I: iprod_q <= 34'(err_q) * 34'(signed'({1'b0, gain_i_q}));
			ST_MUL_T: itot_q <= 44'(iprod_q) * 44'(signed'({1'b0, dt_q}));
			ST_SUM: dsum_q <= 36'(pterm_q) - 36'(dterm_q) + (36'(integ_q) <<< 1) -
				(36'(signed'({1'b0, offs_q})) <<< 1);
			ST_UPDATE: begin
				res_thrust_q <= thr_neg[18] ? 15'd0 :
					(thr_neg > 19'sd65535) ? 15'h7FFF : thr_neg[15:1];
				res_land_q <= land_q;
				res_frozen_q <= frozen;
			end
			default: ;
		endcase
		if (out_load) begin
			thrust_q <= res_thrust_q;
			landing_active_q <= res_land_q;
			integrator_frozen_q <= res_frozen_q;
		end
	end

	assign out_valid = out_valid_q;
	assign thrust = thrust_q;
	assign landing_active = landing_active_q;
	assign integrator_frozen = integrator_frozen_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted transaction did not start the sequencer");

	a_latch_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(landing_latched_q))
		else $error("landing latch cleared without reset");

	a_integ_range: assert property (@(posedge clk) disable iff (!arst_n)
		integ_q <= 17'sd32768 && integ_q >= -17'sd32768)
		else $error("integrator beyond +-1.0");

	a_land_not_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && landing_active_q |-> !integrator_frozen_q)
		else $error("landing result flagged integrator frozen");

endmodule

FILE: bench/altitude_pid_with_landing_tb.sv
// self-checking bench for the altitude pid controller with latched landing
// depends on alt_pkg (register index enum and table depth) and altitude_pid_with_landing
`timescale 1ns / 100ps

module altitude_pid_with_landing_tb;
	import alt_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam longint Q30_ONE_TB = 64'sd1073741824;
	localparam longint Q30_QUARTER_TURN = 64'sd1686629713;

	typedef struct {
		logic signed [15:0] sp;
		logic signed [15:0] pos;
		logic signed [15:0] vel;
		logic signed [15:0] pitch;
		logic signed [15:0] roll;
		logic [9:0] dt;
		logic req;
	} tick_t;

	typedef struct {
		logic [14:0] thrust;
		logic landing;
		logic frozen;
	} thrust_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] setpoint_down = '0;
	logic signed [15:0] position_down = '0;
	logic signed [15:0] velocity_down = '0;
	logic signed [15:0] pitch_angle = '0;
	logic signed [15:0] roll_angle = '0;
	logic [9:0] tick_length = '0;
	logic land_request = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [14:0] thrust;
	logic landing_active;
	logic integrator_frozen;

	altitude_pid_with_landing u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.setpoint_down(setpoint_down), .position_down(position_down),
		.velocity_down(velocity_down), .pitch_angle(pitch_angle),
		.roll_angle(roll_angle), .tick_length(tick_length),
		.land_request(land_request),
		.out_valid(out_valid), .out_stall(out_stall),
		.thrust(thrust), .landing_active(landing_active),
		.integrator_frozen(integrator_frozen)
	);

	// controller shadow: config and state
	longint kp = 0, ki = 0, kd = 0, hover = 18022, alt_limit = -1024;
	longint range_on = 1, stage_len = 100;
	longint integ = 0;
	bit landing_latched = 0;
	longint landing_count = 0;
	logic [15:0] cosine_q15 [0:COS_TABLE_DEPTH];

	tick_t pending_ticks[$];
	thrust_res_t expected_thrust[$];
	tick_t cur;
	bit busy = 0;
	int gap_left = 0;
	int n_issued = 0, n_accepted = 0, n_results = 0;
	int n_landing = 0, n_frozen = 0;
	int errors = 0;
	bit quiet = 0;
	bit hold_request = 0, hold_done = 0;
	int hold_left = 0, ostall_left = 0;
	int idle_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] taylor_cos_q15(int k);
		longint ang, ang_sq, term, acc;
		ang = longint'(k) * Q30_QUARTER_TURN / COS_TABLE_DEPTH;
		ang_sq = (ang * ang) >>> 30;
		term = Q30_ONE_TB;
		acc = Q30_ONE_TB;
		for (int n = 1; n <= 10; n++) begin
			term = -(term * ang_sq / Q30_ONE_TB) / longint'((2 * n - 1) * (2 * n));
			acc += term;
		end
		if (acc < 0) acc = 0;
		acc = (acc + 16384) >>> 15;
		if (acc > 32768) acc = 32768;
		return acc[15:0];
	endfunction

	function automatic longint tilt_cos(logic signed [15:0] ang);
		longint mag, idx;
		mag = ang < 0 ? -longint'(ang) : longint'(ang);
		if (mag > 23040) mag = 23040;
		idx = (mag * COS_TABLE_DEPTH + 11520) / 23040;
		if (idx > COS_TABLE_DEPTH) idx = COS_TABLE_DEPTH;
		return longint'(cosine_q15[idx]);
	endfunction

	function automatic thrust_res_t predict_thrust(tick_t t);
		thrust_res_t r;
		longint lt, cprod, offs, err, dsum, umax, umin, step, thr;
		bit frz;
		if (longint'(t.pos) < alt_limit || t.req || landing_latched) begin
			if (landing_count < stage_len) lt = hover - 1966;
			else if (landing_count < 2 * stage_len) lt = hover - 3932;
			else lt = hover - 6554;
			if (lt < 0) lt = 0;
			if (lt > 32767) lt = 32767;
			if (landing_count < 262143) landing_count++;
			landing_latched = 1;
			r.thrust = lt[14:0];
			r.landing = 1;
			r.frozen = 0;
			return r;
		end
		cprod = tilt_cos(t.pitch) * tilt_cos(t.roll);
		if (cprod == 0 || hover * Q30_ONE_TB >= 65536 * cprod) offs = 65536;
		else offs = hover * Q30_ONE_TB / cprod;
		err = range_on ? longint'(t.sp) - longint'(t.pos) : longint'(t.sp);
		dsum = kp * err - kd * longint'(t.vel) + 2 * integ - 2 * offs;
		umax = 2 * (8192 - hover);
		umin = 2 * (-8192 - hover);
		frz = (dsum >= umax && err >= 0) || (dsum <= umin && err <= 0);
		if (!frz) begin
			step = 2 * integ + err * ki * longint'(t.dt);
			if (step > 65536) step = 65536;
			if (step < -65536) step = -65536;
			integ = step / 2;
		end
		thr = dsum > umin ? (dsum < umax ? dsum : umax) : umin;
		thr = -thr;
		if (thr < 0) thr = 0;
		if (thr > 65535) thr = 65535;
		thr = thr / 2;
		r.thrust = thr[14:0];
		r.landing = 0;
		r.frozen = frz;
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			REG_GAIN_P: kp = val;
			REG_GAIN_I: ki = val;
			REG_GAIN_D: kd = val;
			REG_HOVER: hover = val[14:0];
			REG_ALT_LIMIT: alt_limit = longint'($signed(val));
			REG_USE_RANGE: range_on = val[0];
			REG_STAGE_TICKS: stage_len = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic signed [15:0] rand_angle();
		case ($urandom_range(0, 9))
			0: return 16'($urandom());
			1: return $urandom_range(0, 1) ? 16'sd23040 - 16'($urandom_range(0, 200))
				: -16'sd23040 + 16'($urandom_range(0, 200));
			default: return 16'($signed(32'($urandom_range(0, 46080)) - 23040));
		endcase
	endfunction

	function automatic logic signed [15:0] rand_q78();
		// mostly near zero so the loop is not pinned at a limit
		if ($urandom_range(0, 2) == 0) return 16'($urandom());
		return 16'($signed(32'($urandom_range(0, 1024)) - 512));
	endfunction

	function automatic tick_t rand_tick(bit land);
		tick_t t;
		t.sp = rand_q78();
		t.pos = rand_q78();
		t.vel = rand_q78();
		t.pitch = rand_angle();
		t.roll = rand_angle();
		t.dt = 10'($urandom());
		t.req = land ? 1'($urandom()) : 1'b0;
		return t;
	endfunction

	task automatic push_tick(logic signed [15:0] sp, logic signed [15:0] pos,
		logic signed [15:0] vel, logic signed [15:0] pitch, logic signed [15:0] roll,
		logic [9:0] dt, logic req);
		tick_t t;
		t.sp = sp; t.pos = pos; t.vel = vel;
		t.pitch = pitch; t.roll = roll; t.dt = dt; t.req = req;
		pending_ticks = {pending_ticks, t};
	endtask

	task automatic run_phase(int n, bit land);
		for (int i = 0; i < n; i++) pending_ticks = {pending_ticks, rand_tick(land)};
		wait (pending_ticks.size() == 0 && !busy && expected_thrust.size() == 0);
		repeat (70) @(posedge clk);
	endtask

	// driver: one transaction on the bus at a time, random gaps after acceptance
	always @(negedge clk) begin
		if (busy && n_accepted == n_issued) begin
			busy = 0;
			if (!quiet && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 12);
		end
		if (!busy) begin
			if (gap_left > 0) gap_left--;
			else if (pending_ticks.size() > 0) begin
				cur = pending_ticks.pop_front();
				busy = 1;
				n_issued++;
			end
		end
		in_valid = busy;
		setpoint_down = cur.sp;
		position_down = cur.pos;
		velocity_down = cur.vel;
		pitch_angle = cur.pitch;
		roll_angle = cur.roll;
		tick_length = cur.dt;
		land_request = cur.req;
	end

	// output stall: random bursts plus one long hold-off
	always @(negedge clk) begin
		if (hold_request && !hold_done) begin
			hold_done = 1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) hold_left--;
		else if (ostall_left > 0) ostall_left--;
		else if (!quiet && $urandom_range(0, 6) == 0) ostall_left = $urandom_range(1, 12);
		out_stall = (hold_left > 0 || ostall_left > 0);
	end

	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			n_accepted++;
			expected_thrust = {expected_thrust, predict_thrust(cur)};
		end
	end

	always @(posedge clk) begin
		thrust_res_t e;
		if (out_valid && !out_stall) begin
			n_results++;
			if (landing_active) n_landing++;
			if (integrator_frozen) n_frozen++;
			if (expected_thrust.size() == 0) begin
				report("unexpected result transaction count", n_results, n_accepted);
			end else begin
				e = expected_thrust.pop_front();
				if (thrust !== e.thrust) report("thrust", thrust, e.thrust);
				if (landing_active !== e.landing) report("landing_active", landing_active, e.landing);
				if (integrator_frozen !== e.frozen)
					report("integrator_frozen", integrator_frozen, e.frozen);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else if (arst_n) idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k <= COS_TABLE_DEPTH; k++) cosine_q15[k] = taylor_cos_q15(k);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// pid phases keep the altitude limit at its floor so nothing latches landing
		write_reg(REG_GAIN_P, 16'd256);
		write_reg(REG_GAIN_I, 16'd64);
		write_reg(REG_GAIN_D, 16'd128);
		write_reg(REG_HOVER, 16'd18022);
		write_reg(REG_ALT_LIMIT, 16'h8000);
		write_reg(REG_USE_RANGE, 16'd1);
		write_reg(REG_STAGE_TICKS, 16'd100);
		push_tick(0, 0, 0, 0, 0, 0, 0);
		push_tick(16'sh7FFF, -16'sh8000, 0, 0, 0, 10'd1023, 0);
		push_tick(-16'sh8000, 16'sh7FFF, 0, 0, 0, 10'd1023, 0);
		push_tick(0, 0, 16'sh7FFF, 0, 0, 10'd20, 0);
		push_tick(0, 0, -16'sh8000, 0, 0, 10'd20, 0);
		push_tick(256, 0, 0, 16'sd23040, 0, 10'd20, 0);
		push_tick(256, 0, 0, 0, -16'sd23040, 10'd20, 0);
		push_tick(256, 0, 0, 16'sd23040, 16'sd23040, 10'd20, 0);
		push_tick(-256, 0, 0, 16'sh7FFF, -16'sh8000, 10'd20, 0);
		push_tick(0, 0, 0, 16'sd11520, 16'sd11520, 10'd20, 0);
		push_tick(0, 0, 0, -16'sd20000, 16'sd15000, 10'd0, 0);
		push_tick(16'sh7FFF, 0, 0, 0, 0, 10'd1023, 0);
		push_tick(16'sh7FFF, 0, 0, 0, 0, 10'd1023, 0);
		push_tick(-16'sh8000, 0, 0, 0, 0, 10'd1023, 0);
		push_tick(-16'sh8000, 0, 0, 0, 0, 10'd1023, 0);
		push_tick(100, 50, -30, 300, -300, 10'd512, 0);
		run_phase(90, 0);

		write_reg(REG_GAIN_P, 16'($urandom_range(0, 600)));
		write_reg(REG_GAIN_I, 16'($urandom_range(0, 300)));
		write_reg(REG_GAIN_D, 16'($urandom_range(0, 600)));
		run_phase(90, 0);

		write_reg(REG_GAIN_P, 16'hFFFF);
		write_reg(REG_GAIN_I, 16'hFFFF);
		write_reg(REG_GAIN_D, 16'hFFFF);
		write_reg(REG_HOVER, 16'hFFFF);
		write_reg(REG_USE_RANGE, 16'hFFFE);
		write_reg(REG_UNUSED, 16'($urandom()));
		run_phase(90, 0);

		write_reg(REG_GAIN_P, 16'd0);
		write_reg(REG_GAIN_I, 16'd0);
		write_reg(REG_GAIN_D, 16'd0);
		write_reg(REG_HOVER, 16'd0);
		hold_request = 1;
		run_phase(90, 0);

		write_reg(REG_GAIN_P, 16'($urandom()));
		write_reg(REG_GAIN_I, 16'($urandom()));
		write_reg(REG_GAIN_D, 16'($urandom()));
		write_reg(REG_HOVER, 16'($urandom()));
		write_reg(REG_USE_RANGE, 16'($urandom()));
		run_phase(90, 0);

		write_reg(REG_GAIN_P, 16'($urandom_range(0, 400)));
		write_reg(REG_GAIN_I, 16'($urandom_range(0, 100)));
		write_reg(REG_GAIN_D, 16'($urandom_range(0, 400)));
		write_reg(REG_HOVER, 16'($urandom_range(10000, 26000)));
		write_reg(REG_USE_RANGE, 16'd1);
		run_phase(90, 0);

		// landing latches for the rest of the run: first tick enters on position
		write_reg(REG_ALT_LIMIT, 16'd0);
		write_reg(REG_STAGE_TICKS, 16'd3);
		push_tick(0, -16'sd100, 0, 0, 0, 10'd20, 0);
		run_phase(50, 1);

		write_reg(REG_STAGE_TICKS, 16'd0);
		write_reg(REG_HOVER, 16'd0);
		run_phase(20, 1);

		quiet = 1;
		write_reg(REG_STAGE_TICKS, 16'hFFFF);
		write_reg(REG_HOVER, 16'h7FFF);
		write_reg(REG_ALT_LIMIT, 16'h7FFF);
		run_phase(30, 1);

		$display("covered %0d ticks over pid and landing phases: %0d landing results, %0d frozen",
			n_accepted, n_landing, n_frozen);
		$display("config sweeps included gain and hover extremes plus a long output hold-off");
		if (errors == 0 && expected_thrust.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: filelist.f
src/alt_pkg.sv
src/alt_div.sv
src/altitude_pid_with_landing.sv
bench/altitude_pid_with_landing_tb.sv
